// ----- rtl/cstrip_pkg.sv -----
`timescale 1ns / 1ps

package cstrip_pkg;

  // character codes
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;

  // scanner modes
  localparam logic [2:0] ModeNormal  = 3'd0;
  localparam logic [2:0] ModeString  = 3'd1;
  localparam logic [2:0] ModeChar    = 3'd2;
  localparam logic [2:0] ModeHeader  = 3'd3;
  localparam logic [2:0] ModeComment = 3'd4;

  // configuration register indexes
  localparam logic RegTrigraphs = 1'b0;
  localparam logic RegDigraphs  = 1'b1;

  // queue between scanner and serializer
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] char_in;
    logic       include_context;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
    logic       comment_open;
  } out_t;

  // all result bytes of one input transfer
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] ch;
    logic            comment_open;
  } bundle_t;

  // queue handshake from the scanner toward the queue
  typedef struct packed {
    logic    push;
    bundle_t data;
  } push_t;

endpackage

// ----- rtl/cstrip_front.sv -----
`timescale 1ns / 1ps

module cstrip_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cstrip_pkg::in_t      in_data_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic                 cfg_data_i,
  input  logic                 q_full_i,
  output cstrip_pkg::push_t    push_o
);

  typedef struct packed {
    logic [2:0][7:0] w;
    logic [1:0]      n;
    logic [2:0]      mode;
    logic [7:0]      prev;
    logic            star;
    logic            discard;
    logic            emit;
    logic [7:0]      ch;
  } scan_t;

  function automatic logic [7:0] tri_map(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h28:   r = 8'h5B; // ( -> [
      8'h29:   r = 8'h5D; // ) -> ]
      8'h3C:   r = 8'h7B; // < -> {
      8'h3E:   r = 8'h7D; // > -> }
      8'h3D:   r = 8'h23; // = -> #
      8'h2F:   r = 8'h5C; // / -> backslash
      8'h27:   r = 8'h5E; // ' -> ^
      8'h21:   r = 8'h7C; // ! -> |
      8'h2D:   r = 8'h7E; // - -> ~
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] dig_map(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    if (a == cstrip_pkg::ChLt && b == cstrip_pkg::ChPct) r = 8'h7B;
    else if (a == cstrip_pkg::ChLt && b == cstrip_pkg::ChColon) r = 8'h5B;
    else if (a == cstrip_pkg::ChPct && b == cstrip_pkg::ChGt) r = 8'h7D;
    else if (a == cstrip_pkg::ChPct && b == cstrip_pkg::ChColon) r = 8'h23;
    else if (a == cstrip_pkg::ChColon && b == cstrip_pkg::ChGt) r = 8'h5D;
    return r;
  endfunction

  // decide the byte at the head of the window
  function automatic scan_t decide(scan_t s, logic incl, logic trig, logic dig);
    scan_t      r;
    logic       esc;
    logic [7:0] tm;
    logic [7:0] dm;
    logic       drop1;
    logic       drop2;
    r     = s;
    r.emit = 1'b0;
    r.ch   = s.w[0];
    esc   = (s.prev == cstrip_pkg::ChBslash);
    tm    = tri_map(s.w[2]);
    dm    = dig_map(s.w[0], s.w[1]);
    drop1 = 1'b0;
    drop2 = 1'b0;
    if (trig && s.w[0] == cstrip_pkg::ChQuest && s.w[1] == cstrip_pkg::ChQuest &&
        tm != 8'h00) begin
      r.w[2] = tm;
      drop2  = 1'b1;
    end else begin
      case (s.mode)
        cstrip_pkg::ModeNormal: begin
          drop1  = 1'b1;
          r.emit = 1'b1;
          if (s.w[0] == cstrip_pkg::ChDquote && !esc) begin
            r.mode = cstrip_pkg::ModeString;
          end else if (s.w[0] == cstrip_pkg::ChSquote && !esc) begin
            r.mode = cstrip_pkg::ModeChar;
          end else if (s.w[0] == cstrip_pkg::ChSlash && s.w[1] == cstrip_pkg::ChSlash) begin
            // line comment: one space, window cleared
            r.discard = 1'b1;
            r.prev    = s.w[0];
            r.w       = '0;
            r.n       = 2'd0;
            r.ch      = cstrip_pkg::ChSpace;
            drop1     = 1'b0;
          end else if (s.w[0] == cstrip_pkg::ChSlash && s.w[1] == cstrip_pkg::ChStar) begin
            r.mode = cstrip_pkg::ModeComment;
            r.star = 1'b1;
            r.emit = 1'b0;
          end else if (s.w[0] == cstrip_pkg::ChLt && incl &&
                       !(dig && (s.w[1] == cstrip_pkg::ChPct ||
                                 s.w[1] == cstrip_pkg::ChColon))) begin
            r.mode = cstrip_pkg::ModeHeader;
          end else if (dig && dm != 8'h00) begin
            r.w[1] = dm;
            r.emit = 1'b0;
          end
        end
        cstrip_pkg::ModeString: begin
          drop1  = 1'b1;
          r.emit = 1'b1;
          if (s.w[0] == cstrip_pkg::ChDquote && !esc) r.mode = cstrip_pkg::ModeNormal;
        end
        cstrip_pkg::ModeChar: begin
          drop1  = 1'b1;
          r.emit = 1'b1;
          if (s.w[0] == cstrip_pkg::ChSquote && !esc) r.mode = cstrip_pkg::ModeNormal;
        end
        cstrip_pkg::ModeHeader: begin
          drop1  = 1'b1;
          r.emit = 1'b1;
          if (s.w[0] == cstrip_pkg::ChGt) r.mode = cstrip_pkg::ModeNormal;
        end
        default: begin
          // block comment; the opening star cannot close it
          if (s.w[0] == cstrip_pkg::ChStar && s.w[1] == cstrip_pkg::ChSlash && !s.star) begin
            r.w[1] = cstrip_pkg::ChSpace;
            r.star = 1'b0;
            r.mode = cstrip_pkg::ModeNormal;
            r.emit = 1'b1;
            r.ch   = cstrip_pkg::ChSpace;
            drop2  = 1'b1;
          end else begin
            r.star = 1'b0;
            drop1  = 1'b1;
          end
        end
      endcase
    end
    if (drop1) begin
      r.prev = r.w[0];
      r.w    = {8'h00, r.w[2], r.w[1]};
      r.n    = (r.n != 2'd0) ? r.n - 2'd1 : 2'd0;
    end
    if (drop2) begin
      r.prev = r.w[1];
      r.w    = {16'h0000, r.w[2]};
      r.n    = (r.n > 2'd1) ? r.n - 2'd2 : 2'd0;
    end
    return r;
  endfunction

  logic [1:0][7:0] la_q, la_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      mode_q, mode_d;
  logic [7:0]      prev_q, prev_d;
  logic            discard_q, discard_d;
  logic            star_q, star_d;
  logic            trig_q, dig_q;

  logic            accept;
  logic            eol;
  logic [7:0]      c;
  scan_t           s0, d1, d2, fin;
  cstrip_pkg::bundle_t bnd;

  assign c          = in_data_i.char_in;
  assign eol        = (c == cstrip_pkg::ChLf) || (c == cstrip_pkg::ChCr);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s0         = '0;
    s0.w       = {8'h00, la_q[1], la_q[0]};
    case (cnt_q)
      2'd0:    s0.w[0] = c;
      2'd1:    s0.w[1] = c;
      default: s0.w[2] = c;
    endcase
    s0.n       = eol ? cnt_q : cnt_q + 2'd1;
    s0.mode    = mode_q;
    s0.prev    = prev_q;
    s0.star    = star_q;
    s0.discard = discard_q;
  end

  assign d1 = decide(s0, in_data_i.include_context, trig_q, dig_q);
  assign d2 = decide(d1, in_data_i.include_context, trig_q, dig_q);

  always_comb begin
    fin       = s0;
    bnd       = '0;
    la_d      = la_q;
    cnt_d     = cnt_q;
    mode_d    = mode_q;
    prev_d    = prev_q;
    discard_d = discard_q;
    star_d    = star_q;
    if (!eol) begin
      if (!discard_q) begin
        if (s0.n == 2'd3) begin
          fin = d1;
          if (d1.emit) begin
            bnd.ch[0] = d1.ch;
            bnd.n     = 2'd1;
          end
        end
        la_d[0]   = (fin.n > 2'd0) ? fin.w[0] : 8'h00;
        la_d[1]   = (fin.n > 2'd1) ? fin.w[1] : 8'h00;
        cnt_d     = fin.n;
        mode_d    = fin.mode;
        prev_d    = fin.prev;
        star_d    = fin.star;
        discard_d = fin.discard;
      end
    end else begin
      // end of line flushes the held bytes, then passes the line end unless inside a block comment
      if (s0.n != 2'd0 && !discard_q) begin
        fin = d1;
        if (d1.emit) begin
          bnd.ch[bnd.n] = d1.ch;
          bnd.n         = bnd.n + 2'd1;
        end
        if (d1.n != 2'd0 && !d1.discard) begin
          fin = d2;
          if (d2.emit) begin
            bnd.ch[bnd.n] = d2.ch;
            bnd.n         = bnd.n + 2'd1;
          end
        end
      end
      if (fin.mode != cstrip_pkg::ModeComment) begin
        bnd.ch[bnd.n] = c;
        bnd.n         = bnd.n + 2'd1;
      end
      la_d      = '0;
      cnt_d     = 2'd0;
      mode_d    = fin.mode;
      prev_d    = 8'h00;
      star_d    = fin.star;
      discard_d = 1'b0;
    end
    bnd.comment_open = (mode_d == cstrip_pkg::ModeComment);
  end

  assign push_o.push = accept && (bnd.n != 2'd0);
  assign push_o.data = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q      <= '0;
      cnt_q     <= 2'd0;
      mode_q    <= cstrip_pkg::ModeNormal;
      prev_q    <= 8'h00;
      discard_q <= 1'b0;
      star_q    <= 1'b0;
    end else if (accept) begin
      la_q      <= la_d;
      cnt_q     <= cnt_d;
      mode_q    <= mode_d;
      prev_q    <= prev_d;
      discard_q <= discard_d;
      star_q    <= star_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= 1'b0;
      dig_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cstrip_pkg::RegTrigraphs: trig_q <= cfg_data_i;
        cstrip_pkg::RegDigraphs:  dig_q  <= cfg_data_i;
        default:                  trig_q <= trig_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eol) |=> (cnt_q == 2'd0 && !discard_q && prev_q == 8'h00))
    else $error("window not flushed after line end");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("lookahead holds more than two bytes");
  a_discard_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> cnt_q == 2'd0)
    else $error("bytes held while discarding a line");
`endif

endmodule

// ----- rtl/cstrip_fifo.sv -----
`timescale 1ns / 1ps

module cstrip_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cstrip_pkg::push_t   push_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output cstrip_pkg::bundle_t head_o
);

  cstrip_pkg::bundle_t mem_q [cstrip_pkg::QDepth];
  logic [cstrip_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [cstrip_pkg::QCntW-1:0] cnt_q;
  logic push, pop;

  assign full_o  = (cnt_q == cstrip_pkg::QCntW'(cstrip_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign push    = push_i.push;
  assign pop     = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == cstrip_pkg::QPtrW'(cstrip_pkg::QDepth - 1)) ? '0 :
                wr_q + cstrip_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == cstrip_pkg::QPtrW'(cstrip_pkg::QDepth - 1)) ? '0 :
                rd_q + cstrip_pkg::QPtrW'(1);
      end
      if (push && !pop) cnt_q <= cnt_q + cstrip_pkg::QCntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - cstrip_pkg::QCntW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full_o)
    else $error("queue written while full");
`endif

endmodule

// ----- rtl/cstrip_back.sv -----
`timescale 1ns / 1ps

module cstrip_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  cstrip_pkg::bundle_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cstrip_pkg::out_t    out_data_o
);

  logic [1:0] idx_q;
  logic       last;
  logic       xfer;

  assign out_valid_o = !empty_i;
  assign last        = (idx_q == head_i.n - 2'd1);
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && last;

  assign out_data_o.char_out     = head_i.ch[idx_q];
  assign out_data_o.last_of_run  = last;
  assign out_data_o.comment_open = head_i.comment_open;

  // byte index inside the queued run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (xfer) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < head_i.n))
    else $error("serializer index past end of run");
`endif

endmodule

// ----- rtl/c_source_comment_trigraph_stripper.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                       payload
// in        input      in_valid_i / in_ready_o         in_data_i  (char_in, include_context)
// out       output     out_valid_o / out_ready_i       out_data_o (char_out, last_of_run,
//                                                                  comment_open)
// cfg       input      cfg_we_i                        cfg_idx_i, cfg_data_i
//
// one input byte per cycle while the queue is not full
// an input byte yielding k results takes k output transfers: the output
// serializer sends one byte per cycle while out_ready_i is high, from a two-entry queue
// results are written into the queue on the input transfer and sent from its head
// reset clears the window, mode and options; in_ready_o drops only when the queue is full

module c_source_comment_trigraph_stripper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cstrip_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cstrip_pkg::out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic             cfg_data_i
);

  cstrip_pkg::push_t   push;
  cstrip_pkg::bundle_t head;
  logic                q_full;
  logic                q_empty;
  logic                pop;

  cstrip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  cstrip_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  cstrip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/tb_c_source_comment_trigraph_stripper.sv -----
`timescale 1ns / 1ps

module tb_c_source_comment_trigraph_stripper;

  localparam int IdleLimit  = 2000;
  localparam int LongHold   = 150;
  localparam int PhaseBytes = 55;
  localparam int NumPhases  = 7;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  cstrip_pkg::in_t  in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  cstrip_pkg::out_t out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = 1'b0;
  logic             cfg_data_i  = 1'b0;

  c_source_comment_trigraph_stripper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // source bytes waiting to be offered, output bytes waiting to arrive
  cstrip_pkg::in_t  src_bytes[$];
  cstrip_pkg::out_t expected_chars[$];

  int bytes_queued = 0;
  int bytes_in     = 0;
  int bytes_out    = 0;
  int err_count    = 0;
  int settings_run = 0;
  int idle_cycles  = 0;

  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  int tx_gap     = 0;
  int rx_stall   = 0;
  int rx_next    = 0;
  int holds_asked = 0;
  int holds_taken = 0;

  // stripper state as the testbench sees it
  logic       trig_en;
  logic       dig_en;
  logic [7:0] held [2];
  int         held_n;
  logic [2:0] mode;
  logic [7:0] prev_ch;
  logic       drop_line;
  logic       star_open;
  logic [7:0] scan_win [4];
  int         win_n;

  initial begin
    trig_en   = 1'b0;
    dig_en    = 1'b0;
    held[0]   = '0;
    held[1]   = '0;
    held_n    = 0;
    mode      = cstrip_pkg::ModeNormal;
    prev_ch   = '0;
    drop_line = 1'b0;
    star_open = 1'b0;
  end

  function automatic logic [7:0] trigraph_char(logic [7:0] c);
    case (c)
      "(":  return "[";
      ")":  return "]";
      "<":  return "{";
      ">":  return "}";
      "=":  return "#";
      "/":  return cstrip_pkg::ChBslash;
      "'":  return "^";
      "!":  return "|";
      "-":  return "~";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] digraph_char(logic [7:0] a, logic [7:0] b);
    if (a == cstrip_pkg::ChLt && b == cstrip_pkg::ChPct) return "{";
    if (a == cstrip_pkg::ChLt && b == cstrip_pkg::ChColon) return "[";
    if (a == cstrip_pkg::ChPct && b == cstrip_pkg::ChGt) return "}";
    if (a == cstrip_pkg::ChPct && b == cstrip_pkg::ChColon) return "#";
    if (a == cstrip_pkg::ChColon && b == cstrip_pkg::ChGt) return "]";
    return 8'h00;
  endfunction

  function automatic void advance_window(int k);
    int i;
    prev_ch = scan_win[k - 1];
    for (i = 0; i < 4; i++) scan_win[i] = (i + k < 4) ? scan_win[i + k] : 8'h00;
    win_n = (win_n > k) ? win_n - k : 0;
  endfunction

  // decide the front byte of the window; -1 when nothing comes out
  function automatic int settle_front(logic incl);
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       esc;
    int         i;
    c0  = scan_win[0];
    c1  = scan_win[1];
    c2  = scan_win[2];
    esc = (prev_ch == cstrip_pkg::ChBslash);
    if (trig_en && c0 == cstrip_pkg::ChQuest && c1 == cstrip_pkg::ChQuest &&
        trigraph_char(c2) != 8'h00) begin
      scan_win[2] = trigraph_char(c2);
      advance_window(2);
      return -1;
    end
    case (mode)
      cstrip_pkg::ModeNormal: begin
        if (c0 == cstrip_pkg::ChDquote && !esc) begin
          mode = cstrip_pkg::ModeString;
        end else if (c0 == cstrip_pkg::ChSquote && !esc) begin
          mode = cstrip_pkg::ModeChar;
        end else if (c0 == cstrip_pkg::ChSlash && c1 == cstrip_pkg::ChSlash) begin
          drop_line = 1'b1;
          prev_ch   = c0;
          for (i = 0; i < 4; i++) scan_win[i] = 8'h00;
          win_n = 0;
          return cstrip_pkg::ChSpace;
        end else if (c0 == cstrip_pkg::ChSlash && c1 == cstrip_pkg::ChStar) begin
          mode      = cstrip_pkg::ModeComment;
          star_open = 1'b1;
          advance_window(1);
          return -1;
        end else if (c0 == cstrip_pkg::ChLt && incl &&
                     !(dig_en && (c1 == cstrip_pkg::ChPct || c1 == cstrip_pkg::ChColon))) begin
          mode = cstrip_pkg::ModeHeader;
        end else if (dig_en && digraph_char(c0, c1) != 8'h00) begin
          scan_win[1] = digraph_char(c0, c1);
          advance_window(1);
          return -1;
        end
      end
      cstrip_pkg::ModeString: begin
        if (c0 == cstrip_pkg::ChDquote && !esc) mode = cstrip_pkg::ModeNormal;
      end
      cstrip_pkg::ModeChar: begin
        if (c0 == cstrip_pkg::ChSquote && !esc) mode = cstrip_pkg::ModeNormal;
      end
      cstrip_pkg::ModeHeader: begin
        if (c0 == cstrip_pkg::ChGt) mode = cstrip_pkg::ModeNormal;
      end
      default: begin
        // the star of the opener never closes the comment
        if (c0 == cstrip_pkg::ChStar && c1 == cstrip_pkg::ChSlash && !star_open) begin
          scan_win[1] = cstrip_pkg::ChSpace;
          star_open   = 1'b0;
          mode        = cstrip_pkg::ModeNormal;
          advance_window(2);
          return cstrip_pkg::ChSpace;
        end
        star_open = 1'b0;
        advance_window(1);
        return -1;
      end
    endcase
    advance_window(1);
    return c0;
  endfunction

  function automatic void strip_byte(cstrip_pkg::in_t item);
    logic [7:0]       c;
    logic             eol;
    logic [7:0]       res [3];
    int               n_res;
    int               v;
    int               k;
    cstrip_pkg::out_t r;
    c     = item.char_in;
    eol   = (c == cstrip_pkg::ChLf || c == cstrip_pkg::ChCr);
    n_res = 0;
    for (k = 0; k < 4; k++) scan_win[k] = 8'h00;
    win_n = held_n;
    for (k = 0; k < held_n; k++) scan_win[k] = held[k];
    if (!eol) begin
      if (drop_line) return;
      scan_win[win_n] = c;
      win_n++;
      if (win_n == 3) begin
        v = settle_front(item.include_context);
        if (v >= 0) begin
          res[n_res] = v[7:0];
          n_res++;
        end
      end
    end else begin
      // end of line flushes the window, each held byte looking at it
      scan_win[win_n] = c;
      while (win_n > 0 && !drop_line && n_res < 2) begin
        v = settle_front(item.include_context);
        if (v >= 0) begin
          res[n_res] = v[7:0];
          n_res++;
        end
      end
      if (mode != cstrip_pkg::ModeComment) begin
        res[n_res] = c;
        n_res++;
      end
      drop_line = 1'b0;
      prev_ch   = 8'h00;
      win_n     = 0;
    end
    held_n  = win_n;
    held[0] = (win_n > 0) ? scan_win[0] : 8'h00;
    held[1] = (win_n > 1) ? scan_win[1] : 8'h00;
    for (k = 0; k < n_res; k++) begin
      r.char_out     = res[k];
      r.last_of_run  = (k == n_res - 1);
      r.comment_open = (mode == cstrip_pkg::ModeComment);
      expected_chars = {expected_chars, r};
    end
  endfunction

  function automatic void check_result(cstrip_pkg::out_t got);
    cstrip_pkg::out_t want;
    bytes_out++;
    if (expected_chars.size() == 0) begin
      $error("unexpected output byte %h", got.char_out);
      err_count++;
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_out !== want.char_out) begin
      $error("char_out: expected %h, got %h", want.char_out, got.char_out);
      err_count++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
      err_count++;
    end
    if (got.comment_open !== want.comment_open) begin
      $error("comment_open: expected %b, got %b", want.comment_open, got.comment_open);
      err_count++;
    end
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        strip_byte(in_data_i);
        bytes_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (src_bytes.size() != 0) begin
          in_data_i  <= src_bytes.pop_front();
          in_valid_i <= 1'b1;
          tx_gap     <= tx_no_idle ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall    <= 0;
      holds_taken <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        rx_next = rx_no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        rx_next = (rx_stall > 0) ? rx_stall - 1 : 0;
      end
      // long hold so the output queue fills and input stalls
      if (holds_taken != holds_asked) begin
        rx_next = LongHold;
        holds_taken <= holds_asked;
      end
      rx_stall    <= rx_next;
      out_ready_i <= (rx_next == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_byte(logic [7:0] c, logic incl);
    cstrip_pkg::in_t item;
    item.char_in         = c;
    item.include_context = incl;
    src_bytes = {src_bytes, item};
    bytes_queued++;
  endfunction

  function automatic void push_text(string s, logic incl);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], incl);
  endfunction

  task automatic write_option(input logic idx, input logic val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cstrip_pkg::RegTrigraphs) trig_en = val;
    else dig_en = val;
  endtask

  task automatic wait_for_outputs();
    while (src_bytes.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void directed_bytes();
    push_text("??(<:", 1'b0);
    // string with escaped quote, then char literal with escaped quote
    push_text("\"\\\"\"'\\''", 1'b0);
    // opener slash star slash stays open across the line
    push_text("/*/", 1'b0);
    push_byte(cstrip_pkg::ChLf, 1'b0);
    push_text("*/", 1'b0);
    push_text("<h>", 1'b1);
    push_text("//z", 1'b0);
    push_byte(cstrip_pkg::ChCr, 1'b0);
    push_byte(cstrip_pkg::ChLf, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(cstrip_pkg::ChLf, 1'b1);
  endfunction

  function automatic void random_text(int count);
    int    stop;
    int    sel;
    int    k;
    int    j;
    logic  incl;
    string punct;
    string digr;
    stop  = bytes_queued + count;
    punct = "?/*<%:>\"'\\()=!-#{} ;";
    digr  = "<%<:%>%::>";
    while (bytes_queued < stop) begin
      sel  = $urandom_range(0, 99);
      incl = ($urandom_range(0, 5) == 0);
      if (sel < 30) begin
        push_byte(8'(8'h61 + $urandom_range(0, 25)), incl);
      end else if (sel < 52) begin
        push_byte(punct[$urandom_range(0, punct.len() - 1)], incl);
      end else if (sel < 58) begin
        if ($urandom_range(0, 1)) push_byte(cstrip_pkg::ChCr, incl);
        push_byte(cstrip_pkg::ChLf, incl);
      end else if (sel < 64) begin
        push_byte(8'($urandom_range(0, 255)), incl);
      end else if (sel < 74) begin
        push_text("??", incl);
        push_byte(punct[$urandom_range(0, punct.len() - 1)], incl);
      end else if (sel < 82) begin
        push_text("/*", incl);
        k = $urandom_range(0, 4);
        for (j = 0; j < k; j++) begin
          if ($urandom_range(0, 5) == 0) push_byte(cstrip_pkg::ChLf, incl);
          else push_byte(punct[$urandom_range(0, punct.len() - 1)], incl);
        end
        push_text("*/", incl);
      end else if (sel < 87) begin
        push_text("//", incl);
        k = $urandom_range(0, 4);
        for (j = 0; j < k; j++) push_byte(8'(8'h61 + $urandom_range(0, 25)), incl);
        push_byte(cstrip_pkg::ChLf, incl);
      end else if (sel < 93) begin
        push_byte($urandom_range(0, 1) ? cstrip_pkg::ChDquote : cstrip_pkg::ChSquote, incl);
        k = $urandom_range(0, 3);
        for (j = 0; j < k; j++) begin
          if ($urandom_range(0, 2) == 0) push_byte(cstrip_pkg::ChBslash, incl);
          push_byte(punct[$urandom_range(0, punct.len() - 1)], incl);
        end
        push_byte($urandom_range(0, 1) ? cstrip_pkg::ChDquote : cstrip_pkg::ChSquote, incl);
      end else if (sel < 97) begin
        j = 2 * $urandom_range(0, 4);
        push_byte(digr[j], incl);
        push_byte(digr[j + 1], incl);
      end else begin
        push_byte(cstrip_pkg::ChLt, 1'b1);
        k = $urandom_range(1, 3);
        for (j = 0; j < k; j++) push_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b1);
        push_byte(cstrip_pkg::ChGt, 1'b1);
      end
    end
  endfunction

  initial begin
    int         ph;
    logic [1:0] opts [NumPhases];
    opts[0] = 2'b11;
    opts[1] = 2'b00;
    opts[2] = 2'b11;
    opts[3] = 2'b10;
    opts[4] = 2'b01;
    opts[5] = 2'($urandom_range(0, 3));
    opts[6] = 2'($urandom_range(0, 3));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < NumPhases; ph++) begin
      write_option(cstrip_pkg::RegTrigraphs, opts[ph][1]);
      write_option(cstrip_pkg::RegDigraphs, opts[ph][0]);
      settings_run++;
      @(negedge clk_i);
      tx_no_idle = (ph == 2 || ph == 5);
      rx_no_idle = (ph == 5 || ph == 6);
      if (ph == 2) holds_asked++;
      if (ph == 0) directed_bytes();
      else random_text(PhaseBytes);
      wait_for_outputs();
    end
    repeat (10) @(posedge clk_i);
    $display("run covered %0d source bytes and %0d output bytes over %0d option settings,",
             bytes_in, bytes_out, settings_run);
    $display("with random idling, one long output stall and drained pauses between settings");
    if (err_count == 0 && expected_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
